// File: hw/rtl/rhh_pkg.sv
// rhh_pkg: shared types, codes and constants for the robin hood hash map
// used by the datapath, controller, top level and checker; no dependencies
`timescale 1ns / 1ps

package rhh_pkg;

    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_INDEX_BITS = 20;
    localparam int KEY_W          = 64;
    localparam int COUNT_OUT_W    = 11;
    localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;

    // operation codes carried in tuser of the request beat
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_FIND   = 2'd1,
        FN_ERASE  = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    // result codes carried in tuser of the response beat
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ERASED    = 3'd4,
        ST_FULL      = 3'd5,
        ST_RESERVED  = 3'd6
    } status_t;

    // table write data source
    typedef enum logic [1:0] {
        WR_CARRY  = 2'd0,
        WR_UPDATE = 2'd1,
        WR_SHIFT  = 2'd2,
        WR_ZERO   = 2'd3
    } wr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    mul_step;
        logic    set_home;
        logic    advance;
        logic    swap;
        logic    shift_start;
        logic    shift_adv;
        logic    clr_start;
        logic    clr_step;
        logic    wr_en;
        logic    wr_pos;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    res_ld;
        status_t res_status;
        logic    res_found;
        logic    out_ld;
    } rhh_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic key_zero;
        logic mul_last;
        logic slot_empty;
        logic key_match;
        logic dist_gt;
        logic slot_dist_zero;
        logic n_last;
        logic count_full;
        logic sweep_last;
    } rhh_sts_t;

endpackage

// File: hw/rtl/rhh_ram.sv
// rhh_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/rhh_datapath.sv
// rhh_datapath: slot table, hash multiplier, probe pointers and result registers
// depends on rhh_pkg and rhh_ram
`timescale 1ns / 1ps

module rhh_datapath #(
    parameter int CAPACITY   = rhh_pkg::DEF_CAPACITY,
    parameter int INDEX_BITS = rhh_pkg::DEF_INDEX_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rhh_pkg::rhh_cmd_t             cmd,
    output rhh_pkg::rhh_sts_t             sts,
    input  logic [rhh_pkg::KEY_W-1:0]     in_key,
    input  logic [INDEX_BITS-1:0]         in_value,
    output logic [2:0]                    out_status,
    output logic [INDEX_BITS-1:0]         out_value,
    output logic [rhh_pkg::COUNT_OUT_W-1:0] out_count
);

    localparam int KW = rhh_pkg::KEY_W;
    localparam int VW = INDEX_BITS;
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = KW + VW + SW;
    localparam int OW = rhh_pkg::COUNT_OUT_W;
    localparam logic [SW-1:0] LAST    = SW'(CAPACITY - 1);
    localparam logic [SW:0]   CAP_EXT = (SW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [KW-1:0] ck_reg;
    logic [VW-1:0] cv_reg;
    logic [SW-1:0] dist_reg;
    logic [SW-1:0] slot_reg;
    logic [SW-1:0] pos_reg;
    logic [SW-1:0] n_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]    mul_cnt_reg;
    logic [31:0]   acc_reg;
    logic [2:0]    res_status_reg;
    logic [VW-1:0] res_value_reg;
    logic [2:0]    out_status_reg;
    logic [VW-1:0] out_value_reg;
    logic [OW-1:0] out_count_reg;

    logic [RW-1:0] rdata;
    logic [RW-1:0] wdata;
    logic [SW-1:0] waddr;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [SW-1:0] r_dist;
    logic [SW-1:0] slot_nx;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [SW-1:0] hv;
    logic [SW-1:0] home;
    logic [CW+OW-1:0] cnt_ext;

    assign r_key  = rdata[KW-1:0];
    assign r_val  = rdata[KW+VW-1:KW];
    assign r_dist = rdata[RW-1:KW+VW];

    assign slot_nx = (slot_reg == LAST) ? '0 : slot_reg + 1'b1;

    // slot table
    assign waddr = cmd.wr_pos ? pos_reg : slot_reg;

    always_comb
    begin
        case (cmd.wr_sel)
            rhh_pkg::WR_CARRY:  wdata = {dist_reg, cv_reg, ck_reg};
            rhh_pkg::WR_UPDATE: wdata = {r_dist, val_reg, r_key};
            rhh_pkg::WR_SHIFT:  wdata = {r_dist - 1'b1, r_val, r_key};
            default:            wdata = '0;
        endcase
    end

    rhh_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // shared 32x32 multiplier for the upper half of key * golden
    always_comb
    begin
        case (mul_cnt_reg)
            2'd0:
            begin
                mul_a = key_reg[31:0];
                mul_b = rhh_pkg::GOLDEN[31:0];
            end
            2'd1:
            begin
                mul_a = key_reg[63:32];
                mul_b = rhh_pkg::GOLDEN[31:0];
            end
            default:
            begin
                mul_a = key_reg[31:0];
                mul_b = rhh_pkg::GOLDEN[63:32];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // home slot: top bits of the product, folded once below capacity
    assign hv   = acc_reg[31 -: SW];
    assign home = ({1'b0, hv} >= CAP_EXT) ? SW'({1'b0, hv} - CAP_EXT) : hv;

    // request, hash and carried entry registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            key_reg <= in_key;
            val_reg <= in_value;
        end
        if (cmd.mul_step)
        begin
            acc_reg <= (mul_cnt_reg == 2'd0) ? mul_p[63:32] : acc_reg + mul_p[31:0];
        end
        if (cmd.set_home)
        begin
            ck_reg <= key_reg;
            cv_reg <= val_reg;
        end
        else if (cmd.swap)
        begin
            ck_reg <= r_key;
            cv_reg <= r_val;
        end
        if (cmd.res_ld)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_found ? r_val : '0;
        end
        if (cmd.out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= cnt_ext[OW-1:0];
        end
    end

    assign cnt_ext = {{OW{1'b0}}, count_reg};

    // probe pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            pos_reg     <= '0;
            n_reg       <= '0;
            dist_reg    <= '0;
            count_reg   <= '0;
            mul_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                mul_cnt_reg <= '0;
            end
            else if (cmd.mul_step)
            begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
            end

            if (cmd.clr_start)
            begin
                slot_reg <= '0;
            end
            else if (cmd.set_home)
            begin
                slot_reg <= home;
                n_reg    <= '0;
                dist_reg <= '0;
            end
            else if (cmd.advance)
            begin
                slot_reg <= slot_nx;
                n_reg    <= n_reg + 1'b1;
                dist_reg <= cmd.swap ? r_dist + 1'b1 : dist_reg + 1'b1;
            end
            else if (cmd.shift_start)
            begin
                pos_reg  <= slot_reg;
                slot_reg <= slot_nx;
                n_reg    <= '0;
            end
            else if (cmd.shift_adv)
            begin
                pos_reg  <= slot_reg;
                slot_reg <= slot_nx;
                n_reg    <= n_reg + 1'b1;
            end
            else if (cmd.clr_step)
            begin
                slot_reg <= slot_nx;
            end

            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.cnt_dec && count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // status flags for the controller
    always_comb
    begin
        sts.key_zero       = (key_reg == '0);
        sts.mul_last       = (mul_cnt_reg == 2'd2);
        sts.slot_empty     = (r_key == '0);
        sts.key_match      = (r_key == key_reg);
        sts.dist_gt        = (dist_reg > r_dist);
        sts.slot_dist_zero = (r_dist == '0);
        sts.n_last         = (n_reg == LAST);
        sts.count_full     = (count_reg >= CAP_CNT);
        sts.sweep_last     = (slot_reg == LAST);
    end

    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;

endmodule

// File: hw/rtl/rhh_ctrl.sv
// rhh_ctrl: request sequencer for hash, probe, insert, shift and clear sweeps
// depends on rhh_pkg
`timescale 1ns / 1ps

module rhh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_func,
    output logic              out_valid,
    input  logic              out_ready,
    input  rhh_pkg::rhh_sts_t sts,
    output rhh_pkg::rhh_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_HOME   = 8'b0001_0000,
        S_RD     = 8'b0010_0000,
        S_EV     = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        M_LOC = 2'd0,
        M_INS = 2'd1,
        M_SHF = 2'd2
    } mode_t;

    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    rhh_pkg::func_t  func_reg, func_next;
    logic            clr_op_reg, clr_op_next;
    logic            ovalid_reg, ovalid_next;
    logic            accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign accept    = in_valid && in_ready;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            mode_reg   <= M_LOC;
            func_reg   <= rhh_pkg::FN_INSERT;
            clr_op_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            func_reg   <= func_next;
            clr_op_reg <= clr_op_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        func_next   = func_reg;
        clr_op_next = clr_op_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.wr_sel  = rhh_pkg::WR_ZERO;
        cmd.res_status = rhh_pkg::ST_INSERTED;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    func_next   = rhh_pkg::func_t'(in_func);
                    state_next  = S_DECODE;
                end
            end
            S_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = rhh_pkg::WR_ZERO;
                cmd.clr_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next  = clr_op_reg ? S_DONE : S_IDLE;
                    clr_op_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                if (func_reg == rhh_pkg::FN_CLEAR)
                begin
                    cmd.cnt_clr    = 1'b1;
                    cmd.clr_start  = 1'b1;
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = rhh_pkg::ST_INSERTED;
                    clr_op_next    = 1'b1;
                    state_next     = S_CLEAR;
                end
                else if (sts.key_zero)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = rhh_pkg::ST_RESERVED;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                cmd.set_home = 1'b1;
                mode_next    = M_LOC;
                state_next   = S_RD;
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    M_LOC:
                    begin
                        if (sts.slot_empty || sts.dist_gt)
                        begin
                            // key absent; insert may claim this slot directly
                            cmd.res_ld = 1'b1;
                            if (func_reg != rhh_pkg::FN_INSERT)
                            begin
                                cmd.res_status = rhh_pkg::ST_NOT_FOUND;
                            end
                            else if (sts.count_full)
                            begin
                                cmd.res_status = rhh_pkg::ST_FULL;
                            end
                            else if (sts.slot_empty)
                            begin
                                cmd.wr_en      = 1'b1;
                                cmd.wr_sel     = rhh_pkg::WR_CARRY;
                                cmd.cnt_inc    = 1'b1;
                                cmd.res_status = rhh_pkg::ST_INSERTED;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = rhh_pkg::WR_CARRY;
                                cmd.swap    = 1'b1;
                                cmd.advance = 1'b1;
                                cmd.res_status = rhh_pkg::ST_FULL;
                                if (!sts.n_last)
                                begin
                                    cmd.res_ld = 1'b0;
                                    mode_next  = M_INS;
                                    state_next = S_RD;
                                end
                            end
                        end
                        else if (sts.key_match)
                        begin
                            cmd.res_ld = 1'b1;
                            case (func_reg)
                                rhh_pkg::FN_FIND:
                                begin
                                    cmd.res_status = rhh_pkg::ST_FOUND;
                                    cmd.res_found  = 1'b1;
                                end
                                rhh_pkg::FN_INSERT:
                                begin
                                    cmd.wr_en      = 1'b1;
                                    cmd.wr_sel     = rhh_pkg::WR_UPDATE;
                                    cmd.res_status = rhh_pkg::ST_UPDATED;
                                end
                                default:
                                begin
                                    cmd.res_ld      = 1'b0;
                                    cmd.shift_start = 1'b1;
                                    mode_next       = M_SHF;
                                    state_next      = S_RD;
                                end
                            endcase
                        end
                        else if (sts.n_last)
                        begin
                            // probe bound reached with every slot occupied
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = (func_reg == rhh_pkg::FN_INSERT) ?
                                             rhh_pkg::ST_FULL : rhh_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    M_INS:
                    begin
                        cmd.res_ld = 1'b1;
                        if (sts.slot_empty)
                        begin
                            cmd.wr_en      = 1'b1;
                            cmd.wr_sel     = rhh_pkg::WR_CARRY;
                            cmd.cnt_inc    = 1'b1;
                            cmd.res_status = rhh_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            cmd.wr_en      = sts.dist_gt;
                            cmd.wr_sel     = rhh_pkg::WR_CARRY;
                            cmd.swap       = sts.dist_gt;
                            cmd.advance    = 1'b1;
                            cmd.res_status = rhh_pkg::ST_FULL;
                            if (!sts.n_last)
                            begin
                                cmd.res_ld = 1'b0;
                                state_next = S_RD;
                            end
                        end
                    end
                    default:
                    begin
                        // backward shift of the run after the erased slot
                        cmd.wr_en  = 1'b1;
                        cmd.wr_pos = 1'b1;
                        if (sts.n_last || sts.slot_empty || sts.slot_dist_zero)
                        begin
                            cmd.wr_sel     = rhh_pkg::WR_ZERO;
                            cmd.cnt_dec    = 1'b1;
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = rhh_pkg::ST_ERASED;
                        end
                        else
                        begin
                            cmd.wr_sel    = rhh_pkg::WR_SHIFT;
                            cmd.shift_adv = 1'b1;
                            state_next    = S_RD;
                        end
                    end
                endcase
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_ld  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/robin_hood_hash_map.sv
// robin_hood_hash_map: top level, stream ports around controller and datapath
// depends on rhh_pkg, rhh_ctrl, rhh_datapath
`timescale 1ns / 1ps

// Open-addressing key to pool-index map with robin hood probing.
// Request channel s_axis: tuser holds the operation (insert, find, erase,
// clear), tdata holds key and value. Response channel m_axis: tuser holds
// the result code, tdata holds found value and occupied entry count.
// One request is worked on at a time; s_axis_tready is high only when the
// sequencer is idle. Steps: decode, hash (one shared 32x32 multiplier used
// in turn for three partial products), home, then a table read plus evaluate
// per slot probed or shifted, then a load of the response register.
// Clear sweeps the table one slot a cycle.
// After reset the same sweep runs with s_axis_tready low.
// The response register holds while m_axis_tready is low; the next request
// is still taken and worked on, and waits to load until the register frees.
module robin_hood_hash_map #(
    parameter int CAPACITY   = rhh_pkg::DEF_CAPACITY,
    parameter int INDEX_BITS = rhh_pkg::DEF_INDEX_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // key, value, zero fill
    input  logic [((rhh_pkg::KEY_W + INDEX_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // func
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // found_value, entry_count, zero fill
    output logic [((INDEX_BITS + rhh_pkg::COUNT_OUT_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status
    output logic [2:0] m_axis_tuser
);

    localparam int KW  = rhh_pkg::KEY_W;
    localparam int OW  = rhh_pkg::COUNT_OUT_W;
    localparam int MDW = ((INDEX_BITS + OW + 7) / 8) * 8;

    rhh_pkg::rhh_cmd_t     cmd;
    rhh_pkg::rhh_sts_t     sts;
    logic [2:0]            out_status;
    logic [INDEX_BITS-1:0] out_value;
    logic [OW-1:0]         out_count;

    rhh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rhh_datapath #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_key     (s_axis_tdata[KW-1:0]),
        .in_value   (s_axis_tdata[KW+INDEX_BITS-1:KW]),
        .out_status (out_status),
        .out_value  (out_value),
        .out_count  (out_count)
    );

    // response beat packing
    assign m_axis_tuser = out_status;
    assign m_axis_tdata = MDW'({out_count, out_value});

endmodule

// File: hw/rtl/rhh_checker.sv
// rhh_checker: port-level checks on the request and response channels of the hash map
// depends on rhh_pkg; bound to robin_hood_hash_map
`timescale 1ns / 1ps

module rhh_checker #(
    parameter int CAPACITY   = rhh_pkg::DEF_CAPACITY,
    parameter int INDEX_BITS = rhh_pkg::DEF_INDEX_BITS
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((INDEX_BITS + rhh_pkg::COUNT_OUT_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser
);

    localparam int VW = INDEX_BITS;
    localparam int OW = rhh_pkg::COUNT_OUT_W;
    localparam logic [OW:0] CAP_LIM = (CAPACITY > 2047) ? (OW + 1)'(2047)
                                                         : (OW + 1)'(CAPACITY);

    // a stalled response beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("response beat changed under stall");

    // no undefined result code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 3'd7)
        else $error("undefined result code");

    // found value only on a hit
    a_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != rhh_pkg::ST_FOUND |-> m_axis_tdata[VW-1:0] == '0)
        else $error("value reported without a hit");

    // occupancy never exceeds the table size
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[VW+OW-1:VW]} <= CAP_LIM)
        else $error("entry count above capacity");

    // a request is not taken while the previous one is still being worked on
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken back to back");

endmodule

bind robin_hood_hash_map rhh_checker #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS)
) u_rhh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/rhh_checker.sv
// rhh_scoreboard: watches request and response beats of the hash map,
// predicts each response and compares it field by field; uses rhh_pkg
`timescale 1ns / 1ps

module rhh_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          fails,
    output int          pending
);

    localparam int SLOTS = rhh_pkg::DEF_CAPACITY;

    typedef struct packed {
        rhh_pkg::status_t st;
        logic [19:0]      fv;
        logic [10:0]      cnt;
    } reply_t;

    // shadow copy of the table
    logic [63:0] shadow_key  [SLOTS];
    logic [19:0] shadow_val  [SLOTS];
    logic [9:0]  shadow_dist [SLOTS];
    int          shadow_count;

    reply_t replies_due[$];

    function automatic logic [9:0] home_of(logic [63:0] k);
        logic [63:0] p;
        p = k * rhh_pkg::GOLDEN;
        return p[63:54];
    endfunction

    function automatic bit lookup(logic [63:0] k, output logic [9:0] where);
        logic [9:0] s;
        int d;
        s = home_of(k);
        d = 0;
        where = '0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (shadow_key[s] == 0 || d > shadow_dist[s])
                return 0;
            if (shadow_key[s] == k)
            begin
                where = s;
                return 1;
            end
            d++;
            s = s + 10'd1;
        end
        return 0;
    endfunction

    task automatic wipe_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
            shadow_dist[i] = '0;
        end
        shadow_count = 0;
    endtask

    task automatic do_insert(input logic [63:0] k, input logic [19:0] v,
                             output rhh_pkg::status_t st);
        logic [9:0]  w, s, td;
        logic [63:0] ck, tk;
        logic [19:0] cv, tv;
        logic [9:0]  cd;
        if (lookup(k, w))
        begin
            shadow_val[w] = v;
            st = rhh_pkg::ST_UPDATED;
            return;
        end
        if (shadow_count >= SLOTS)
        begin
            st = rhh_pkg::ST_FULL;
            return;
        end
        ck = k; cv = v; cd = '0;
        s = home_of(k);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (shadow_key[s] == 0)
            begin
                shadow_key[s]  = ck;
                shadow_val[s]  = cv;
                shadow_dist[s] = cd;
                shadow_count++;
                st = rhh_pkg::ST_INSERTED;
                return;
            end
            // robin hood swap with a richer resident
            if (shadow_dist[s] < cd)
            begin
                tk = shadow_key[s]; tv = shadow_val[s]; td = shadow_dist[s];
                shadow_key[s] = ck; shadow_val[s] = cv; shadow_dist[s] = cd;
                ck = tk; cv = tv; cd = td;
            end
            cd = cd + 10'd1;
            s = s + 10'd1;
        end
        st = rhh_pkg::ST_FULL;
    endtask

    task automatic do_erase(input logic [63:0] k, output rhh_pkg::status_t st);
        logic [9:0] pos, nx;
        if (!lookup(k, pos))
        begin
            st = rhh_pkg::ST_NOT_FOUND;
            return;
        end
        // backward shift of the following run
        for (int n = 0; n < SLOTS; n++)
        begin
            nx = pos + 10'd1;
            if (n + 1 >= SLOTS || shadow_key[nx] == 0 || shadow_dist[nx] == 0)
                break;
            shadow_key[pos]  = shadow_key[nx];
            shadow_val[pos]  = shadow_val[nx];
            shadow_dist[pos] = shadow_dist[nx] - 10'd1;
            pos = nx;
        end
        shadow_key[pos] = '0; shadow_val[pos] = '0; shadow_dist[pos] = '0;
        if (shadow_count > 0)
            shadow_count--;
        st = rhh_pkg::ST_ERASED;
    endtask

    task automatic predict_reply(input rhh_pkg::func_t f, input logic [63:0] k,
                                 input logic [19:0] v, output reply_t r);
        logic [9:0] w;
        r = '0;
        if (f == rhh_pkg::FN_CLEAR)
        begin
            wipe_table();
            r.st = rhh_pkg::ST_INSERTED;
        end
        else if (k == 0)
            r.st = rhh_pkg::ST_RESERVED;
        else if (f == rhh_pkg::FN_INSERT)
            do_insert(k, v, r.st);
        else if (f == rhh_pkg::FN_FIND)
        begin
            if (lookup(k, w))
            begin
                r.st = rhh_pkg::ST_FOUND;
                r.fv = shadow_val[w];
            end
            else
                r.st = rhh_pkg::ST_NOT_FOUND;
        end
        else
            do_erase(k, r.st);
        r.cnt = 11'(shadow_count);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fails++;
    endtask

    initial
    begin
        fails   = 0;
        pending = 0;
        wipe_table();
    end

    // predict on request beats, compare on response beats
    always @(posedge clk)
    begin
        reply_t r, e;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_reply(rhh_pkg::func_t'(s_axis_tuser), s_axis_tdata[63:0],
                              s_axis_tdata[83:64], r);
                replies_due.push_back(r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    report_mismatch("unexpected response beat", 32'(m_axis_tuser), 32'd0);
                end
                else
                begin
                    e = replies_due.pop_front();
                    if (m_axis_tuser != e.st)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(e.st));
                    if (m_axis_tdata[19:0] != e.fv)
                        report_mismatch("found_value", 32'(m_axis_tdata[19:0]), 32'(e.fv));
                    if (m_axis_tdata[30:20] != e.cnt)
                        report_mismatch("entry_count", 32'(m_axis_tdata[30:20]), 32'(e.cnt));
                end
            end
            pending = replies_due.size();
        end
    end

endmodule

// File: test/testbench.sv
// testbench: drives request beats into robin_hood_hash_map and gives the verdict
// depends on rhh_pkg, robin_hood_hash_map and rhh_scoreboard
`timescale 1ns / 1ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // key, value, zero fill
    logic [1:0]  s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // found_value, entry_count, zero fill
    logic [2:0]  m_axis_tuser;   // status
    int          fails;
    int          pending;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          rx_hold_req;
    int          beats_sent;
    logic [63:0] key_pool [16];

    robin_hood_hash_map u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    rhh_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fails(fails), .pending(pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // response side readiness, with a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready = 1'b0;
                for (int c = 0; c < 400; c++)
                    @(negedge clk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one request beat, with an optional idle gap before it
    task automatic send_op(input rhh_pkg::func_t f, input logic [63:0] k,
                           input logic [19:0] v);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = f;
        s_axis_tdata  = {4'b0, v, k};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        beats_sent++;
    endtask

    // sender pause until every response is back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0:       begin tx_idle_pct = 30; rx_idle_pct = 80; end
            1:       begin tx_idle_pct = 80; rx_idle_pct = 30; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
    endtask

    // mixed operations over a small key pool so hits are common
    task automatic mixed_ops(input int n);
        int r;
        logic [63:0] k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            k = ($urandom_range(19) == 0) ? {$urandom, $urandom} :
                key_pool[$urandom_range(15)];
            if ($urandom_range(199) == 0)
                k = '0;
            if (r < 45)
                send_op(rhh_pkg::FN_INSERT, k, 20'($urandom));
            else if (r < 75)
                send_op(rhh_pkg::FN_FIND, k, 20'($urandom));
            else if (r < 98)
                send_op(rhh_pkg::FN_ERASE, k, 20'($urandom));
            else
                send_op(rhh_pkg::FN_CLEAR, {$urandom, $urandom}, 20'($urandom));
        end
    endtask

    initial
    begin
        #20000000;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rhh_pkg::FN_INSERT;
        rx_hold_req   = 1'b0;
        beats_sent    = 0;
        set_idling(2);
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, $urandom} | 64'd1;
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every operation, reserved key
        send_op(rhh_pkg::FN_FIND, '1, '0);
        send_op(rhh_pkg::FN_INSERT, '1, '1);
        send_op(rhh_pkg::FN_INSERT, 64'd1, '0);
        send_op(rhh_pkg::FN_FIND, '1, '0);
        send_op(rhh_pkg::FN_INSERT, '1, 20'h5A5A5);
        send_op(rhh_pkg::FN_FIND, '1, '0);
        send_op(rhh_pkg::FN_INSERT, 64'h8000_0000_0000_0000, 20'h80000);
        send_op(rhh_pkg::FN_FIND, 64'd1, '0);
        send_op(rhh_pkg::FN_ERASE, 64'd1, '0);
        send_op(rhh_pkg::FN_ERASE, 64'd1, '0);
        send_op(rhh_pkg::FN_FIND, 64'd1, '0);
        send_op(rhh_pkg::FN_INSERT, '0, '1);
        send_op(rhh_pkg::FN_FIND, '0, '0);
        send_op(rhh_pkg::FN_ERASE, '0, '0);
        send_op(rhh_pkg::FN_CLEAR, '0, '0);
        send_op(rhh_pkg::FN_FIND, '1, '0);
        send_op(rhh_pkg::FN_ERASE, '1, '0);
        drain();

        // long response stall while requests keep coming
        rx_hold_req = 1'b1;
        mixed_ops(12);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            set_idling(ph);
            mixed_ops(40);
            drain();
        end

        // fill to capacity with distinct keys, then probe the full table
        set_idling(2);
        send_op(rhh_pkg::FN_CLEAR, '0, '0);
        for (int i = 0; i < rhh_pkg::DEF_CAPACITY + 6; i++)
        begin
            if (i % 256 == 0)
                set_idling($urandom_range(2));
            send_op(rhh_pkg::FN_INSERT, {$urandom, 32'(i + 1)}, 20'($urandom));
        end
        send_op(rhh_pkg::FN_INSERT, {32'h1234_5678, 32'd7}, 20'h12345);
        send_op(rhh_pkg::FN_FIND, {$urandom, 32'd9}, '0);
        mixed_ops(20);
        drain();

        set_idling(0);
        mixed_ops(10);
        drain();

        // let a trailing clear sweep finish
        repeat (3000) @(posedge clk);
        $display("covered %0d request beats: all four operations, reserved key,", beats_sent);
        $display("full table, long stalls and three idling mixes");
        if (fails == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
